// ===== src/mbs_pkg.sv =====
// ----------------------------------------------------------------------------
// mbs_pkg
// Shared types and constants for the maze backtracker step block.
// ----------------------------------------------------------------------------
package mbs_pkg;

  // fixed field widths
  localparam int CELL_W   = 5;
  localparam int LIMIT_W  = 14;
  localparam int CFG_W    = 13;
  localparam int CFG_IDX_W = 2;
  localparam int X_FLD_W  = 4;
  localparam int Y_FLD_W  = 8;

  // cell word: bit4 visited, bits 3..0 walls
  localparam int          VIS_BIT         = 4;
  localparam logic [3:0]  ALL_WALLS       = 4'hF;
  localparam logic [LIMIT_W-1:0] LIMIT_MAX = 14'd16383;
  localparam logic [CFG_W-1:0] FIRST_LIMIT_RST = 13'd40;
  localparam logic [CFG_W-1:0] LIMIT_STEP_RST  = 13'd60;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_STEP  = 2'd1;

  // carve directions
  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_RIGHT = 2'd1;
  localparam logic [1:0] DIR_DOWN  = 2'd2;
  localparam logic [1:0] DIR_LEFT  = 2'd3;

  typedef enum logic [1:0] {
    ACT_START = 2'd0,
    ACT_STEP  = 2'd1,
    ACT_READ  = 2'd2,
    ACT_NOP   = 2'd3
  } act_t;

  typedef enum logic [2:0] {
    EV_CARVED   = 3'd0,
    EV_BACK     = 3'd1,
    EV_STRIP    = 3'd2,
    EV_FINISHED = 3'd3,
    EV_IDLE     = 3'd4,
    EV_READ     = 3'd5
  } ev_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLR,
    OP_CAPTURE,
    OP_RD_CUR,
    OP_LATCH_CUR,
    OP_RD_NB,
    OP_NEXT_ATT,
    OP_RD_REQ,
    OP_RD_ORIGIN,
    OP_RD_STRIP,
    OP_RD_STACK,
    OP_WR_CUR,
    OP_WR_NB,
    OP_WR_VIS_ORIGIN,
    OP_WR_VIS_STRIP,
    OP_FINISH
  } op_t;

  // controller to datapath
  typedef struct packed {
    op_t  op;
    logic pop_load;
    logic result;
    ev_t  ev;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    act_t action;
    logic started;
    logic done;
    logic att_end;
    logic nb_ok;
    logic nb_visited;
    logic stack_empty;
    logic strip_over;
  } sts_t;

endpackage

// ===== src/mbs_ram.sv =====
// ----------------------------------------------------------------------------
// mbs_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module mbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== src/mbs_dp.sv =====
// ----------------------------------------------------------------------------
// mbs_dp
// Datapath: cell memory, walk stack, current cell, row limit and result.
// ----------------------------------------------------------------------------
module mbs_dp import mbs_pkg::*; #(
  parameter int COLUMNS = 16,
  parameter int ROWS    = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cmd_t                 cmd,
  output sts_t                 sts,
  input  logic [1:0]           in_action,
  input  logic [1:0]           in_pick_first,
  input  logic [1:0]           in_pick_second,
  input  logic                 in_pick_third,
  input  logic [X_FLD_W-1:0]   in_read_x,
  input  logic [Y_FLD_W-1:0]   in_read_y,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output logic [2:0]           out_event_res,
  output logic [X_FLD_W-1:0]   out_pos_x,
  output logic [Y_FLD_W-1:0]   out_pos_y,
  output logic [1:0]           out_direction,
  output logic [3:0]           out_wall_bits,
  output logic                 out_cell_visited
);

  localparam int NCELLS = COLUMNS * ROWS;
  localparam int XW = $clog2(COLUMNS);
  localparam int YW = $clog2(ROWS);
  localparam int AW = $clog2(NCELLS);
  localparam int DW = $clog2(NCELLS + 1);
  localparam int SW = XW + YW;

  // control state
  logic [CFG_W-1:0]   first_lim_r, lim_step_r;
  logic [LIMIT_W-1:0] row_lim_r;
  logic               started_r, done_r;
  logic [DW-1:0]      depth_r;
  logic [XW-1:0]      cur_x_r;
  logic [YW-1:0]      cur_y_r;
  logic [AW-1:0]      clr_idx_r;
  logic [2:0]         att_r;

  // payload
  act_t               act_r;
  logic [X_FLD_W-1:0] req_x_r;
  logic [Y_FLD_W-1:0] req_y_r;
  logic [1:0]         seq_r [4];
  logic [CELL_W-1:0]  cur_word_r;
  logic [1:0]         dir_r;
  logic [2:0]         ev_out_r;
  logic [X_FLD_W-1:0] pos_x_r;
  logic [Y_FLD_W-1:0] pos_y_r;
  logic [1:0]         dir_out_r;
  logic [3:0]         walls_r;
  logic               vis_r;

  // memory ports
  logic              c_we, c_re, s_we, s_re;
  logic [AW-1:0]     c_waddr, c_raddr, s_waddr, s_raddr;
  logic [CELL_W-1:0] c_wdata, c_rdata;
  logic [SW-1:0]     s_wdata, s_rdata;

  logic [1:0]         seq_c [4];
  logic [1:0]         att_dir, opp_dir, p1m;
  logic [1:0]         rem1 [3];
  logic [1:0]         rem2 [2];
  logic               nb_ok;
  logic [XW-1:0]      nb_x;
  logic [YW-1:0]      nb_y;
  logic [YW-1:0]      strip_y;
  logic               strip_over, req_ok, stack_full, push;
  logic [LIMIT_W:0]   lim_sum;
  logic [LIMIT_W-1:0] lim_nxt;
  logic [AW-1:0]      cur_addr, nb_addr, req_addr, strip_addr;

  function automatic logic [AW-1:0] cell_addr(input logic [XW-1:0] x, input logic [YW-1:0] y);
    cell_addr = AW'(AW'(y) * AW'(COLUMNS) + AW'(x));
  endfunction

  // direction order from the picks
  always_comb begin
    p1m = (in_pick_second == 2'd3) ? 2'd0 : in_pick_second;
    for (int k = 0; k < 3; k++) begin
      rem1[k] = (2'(k) < in_pick_first) ? 2'(k) : 2'(k + 1);
    end
    for (int k = 0; k < 2; k++) begin
      rem2[k] = (2'(k) < p1m) ? rem1[k] : rem1[k + 1];
    end
    seq_c[0] = in_pick_first;
    seq_c[1] = rem1[p1m];
    seq_c[2] = rem2[in_pick_third];
    seq_c[3] = rem2[!in_pick_third];
  end

  // neighbour of the current attempt
  assign att_dir = seq_r[att_r[1:0]];
  assign opp_dir = att_dir + 2'd2;

  always_comb begin
    nb_x  = cur_x_r;
    nb_y  = cur_y_r;
    nb_ok = 1'b0;
    case (att_dir)
      DIR_UP: begin
        nb_ok = (cur_y_r != '0);
        nb_y  = cur_y_r - YW'(1);
      end
      DIR_RIGHT: begin
        nb_ok = (32'(cur_x_r) + 1 < COLUMNS);
        nb_x  = cur_x_r + XW'(1);
      end
      DIR_DOWN: begin
        nb_ok = (32'(cur_y_r) + 1 < ROWS) &&
                ((15'(cur_y_r) + 15'd1) < 15'(row_lim_r));
        nb_y  = cur_y_r + YW'(1);
      end
      default: begin
        nb_ok = (cur_x_r != '0);
        nb_x  = cur_x_r - XW'(1);
      end
    endcase
  end

  // limits, addresses and flags
  assign strip_over = (32'(row_lim_r) + 1 >= ROWS);
  assign strip_y    = YW'(row_lim_r + LIMIT_W'(1));
  assign lim_sum    = 15'(row_lim_r) + 15'(lim_step_r);
  assign lim_nxt    = (lim_sum > 15'(LIMIT_MAX)) ? LIMIT_MAX : lim_sum[LIMIT_W-1:0];
  assign req_ok     = (32'(req_x_r) < COLUMNS) && (32'(req_y_r) < ROWS);
  assign stack_full = (depth_r == DW'(NCELLS));
  assign cur_addr   = cell_addr(cur_x_r, cur_y_r);
  assign nb_addr    = cell_addr(nb_x, nb_y);
  assign req_addr   = cell_addr(XW'(req_x_r), YW'(req_y_r));
  assign strip_addr = cell_addr('0, strip_y);

  // memory commands
  always_comb begin
    c_we    = 1'b0;
    c_waddr = cur_addr;
    c_wdata = c_rdata;
    c_re    = 1'b0;
    c_raddr = cur_addr;
    s_re    = 1'b0;
    s_raddr = AW'(depth_r - DW'(1));
    push    = 1'b0;
    s_wdata = {nb_y, nb_x};
    case (cmd.op)
      OP_CLR: begin
        c_we    = 1'b1;
        c_waddr = clr_idx_r;
        c_wdata = {1'b0, ALL_WALLS};
      end
      OP_RD_CUR: c_re = 1'b1;
      OP_RD_NB: begin
        c_re    = 1'b1;
        c_raddr = nb_addr;
      end
      OP_RD_REQ: begin
        c_re    = req_ok;
        c_raddr = req_addr;
      end
      OP_RD_ORIGIN: begin
        c_re    = 1'b1;
        c_raddr = '0;
      end
      OP_RD_STRIP: begin
        c_re    = 1'b1;
        c_raddr = strip_addr;
      end
      OP_RD_STACK: s_re = 1'b1;
      OP_WR_CUR: begin
        c_we    = 1'b1;
        c_wdata = cur_word_r & ~(CELL_W'(1) << att_dir);
      end
      OP_WR_NB: begin
        c_we    = 1'b1;
        c_waddr = nb_addr;
        c_wdata = (c_rdata & ~(CELL_W'(1) << opp_dir)) | (CELL_W'(1) << VIS_BIT);
        push    = 1'b1;
      end
      OP_WR_VIS_ORIGIN: begin
        c_we    = 1'b1;
        c_waddr = '0;
        c_wdata = c_rdata | (CELL_W'(1) << VIS_BIT);
        push    = 1'b1;
        s_wdata = '0;
      end
      OP_WR_VIS_STRIP: begin
        c_we    = 1'b1;
        c_waddr = strip_addr;
        c_wdata = c_rdata | (CELL_W'(1) << VIS_BIT);
        push    = 1'b1;
        s_wdata = {strip_y, XW'(0)};
      end
      default: ;
    endcase
  end

  assign s_we    = push && !stack_full;
  assign s_waddr = AW'(depth_r);

  mbs_ram #(.WIDTH(CELL_W), .DEPTH(NCELLS)) u_cell_ram (
    .clk     (clk),
    .wr_en   (c_we),
    .wr_addr (c_waddr),
    .wr_data (c_wdata),
    .rd_en   (c_re),
    .rd_addr (c_raddr),
    .rd_data (c_rdata)
  );

  mbs_ram #(.WIDTH(SW), .DEPTH(NCELLS)) u_stack_ram (
    .clk     (clk),
    .wr_en   (s_we),
    .wr_addr (s_waddr),
    .wr_data (s_wdata),
    .rd_en   (s_re),
    .rd_addr (s_raddr),
    .rd_data (s_rdata)
  );

  // walk state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_lim_r <= FIRST_LIMIT_RST;
      lim_step_r  <= LIMIT_STEP_RST;
      row_lim_r   <= LIMIT_W'(FIRST_LIMIT_RST);
      started_r   <= 1'b0;
      done_r      <= 1'b0;
      depth_r     <= '0;
      cur_x_r     <= '0;
      cur_y_r     <= '0;
      clr_idx_r   <= '0;
      att_r       <= '0;
    end else begin
      if (cfg_valid && cfg_index == CFG_FIRST_LIMIT) begin
        first_lim_r <= cfg_data;
      end
      if (cfg_valid && cfg_index == CFG_LIMIT_STEP) begin
        lim_step_r <= cfg_data;
      end
      if (s_we) begin
        depth_r <= depth_r + DW'(1);
      end
      if (cmd.pop_load) begin
        {cur_y_r, cur_x_r} <= s_rdata;
      end
      case (cmd.op)
        OP_CLR:      clr_idx_r <= clr_idx_r + AW'(1);
        OP_CAPTURE:  att_r <= '0;
        OP_NEXT_ATT: att_r <= att_r + 3'd1;
        OP_RD_STACK: depth_r <= depth_r - DW'(1);
        OP_WR_NB: begin
          cur_x_r <= nb_x;
          cur_y_r <= nb_y;
        end
        OP_WR_VIS_ORIGIN: begin
          cur_x_r   <= '0;
          cur_y_r   <= '0;
          done_r    <= 1'b0;
          started_r <= 1'b1;
          row_lim_r <= LIMIT_W'(first_lim_r);
        end
        OP_WR_VIS_STRIP: begin
          cur_x_r   <= '0;
          cur_y_r   <= strip_y;
          row_lim_r <= lim_nxt;
        end
        OP_FINISH: begin
          cur_x_r   <= '0;
          cur_y_r   <= '0;
          done_r    <= 1'b1;
          row_lim_r <= lim_nxt;
        end
        default: ;
      endcase
    end
  end

  // captured request and result beat
  always_ff @(posedge clk) begin
    if (cmd.op == OP_CAPTURE) begin
      act_r   <= act_t'(in_action);
      req_x_r <= in_read_x;
      req_y_r <= in_read_y;
      for (int k = 0; k < 4; k++) begin
        seq_r[k] <= seq_c[k];
      end
    end
    if (cmd.op == OP_LATCH_CUR) begin
      cur_word_r <= c_rdata;
    end
    if (cmd.op == OP_WR_NB) begin
      dir_r <= att_dir;
    end
    if (cmd.result) begin
      ev_out_r  <= cmd.ev;
      dir_out_r <= (cmd.ev == EV_CARVED) ? dir_r : 2'd0;
      if (cmd.ev == EV_READ) begin
        pos_x_r <= req_x_r;
        pos_y_r <= req_y_r;
        walls_r <= req_ok ? c_rdata[3:0] : ALL_WALLS;
        vis_r   <= req_ok && c_rdata[VIS_BIT];
      end else begin
        pos_x_r <= X_FLD_W'(cur_x_r);
        pos_y_r <= Y_FLD_W'(cur_y_r);
        walls_r <= 4'd0;
        vis_r   <= 1'b0;
      end
    end
  end

  // status to the controller
  always_comb begin
    sts.clr_last    = (32'(clr_idx_r) == NCELLS - 1);
    sts.action      = act_r;
    sts.started     = started_r;
    sts.done        = done_r;
    sts.att_end     = (att_r == 3'd4);
    sts.nb_ok       = nb_ok;
    sts.nb_visited  = c_rdata[VIS_BIT];
    sts.stack_empty = (depth_r == '0);
    sts.strip_over  = strip_over;
  end

  assign out_event_res    = ev_out_r;
  assign out_pos_x        = pos_x_r;
  assign out_pos_y        = pos_y_r;
  assign out_direction    = dir_out_r;
  assign out_wall_bits    = walls_r;
  assign out_cell_visited = vis_r;

endmodule

// ===== src/mbs_ctrl.sv =====
// ----------------------------------------------------------------------------
// mbs_ctrl
// Controller: sequences memory accesses for each action and owns handshakes.
// ----------------------------------------------------------------------------
module mbs_ctrl import mbs_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DISPATCH,
    S_START_W,
    S_CUR_W,
    S_ATT,
    S_NB_W,
    S_CARVE,
    S_STRIP_W,
    S_POP_W,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;
  ev_t    ev_r, ev_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_ready;

  // next state and commands
  always_comb begin
    state_nxt    = state_r;
    ev_nxt       = ev_r;
    cmd.op       = OP_NONE;
    cmd.pop_load = 1'b0;
    cmd.result   = 1'b0;
    cmd.ev       = ev_r;
    case (state_r)
      S_CLEAR: begin
        cmd.op = OP_CLR;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_CAPTURE;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (sts.action == ACT_START) begin
          cmd.op    = OP_RD_ORIGIN;
          state_nxt = S_START_W;
        end else if (sts.action == ACT_READ) begin
          cmd.op    = OP_RD_REQ;
          ev_nxt    = EV_READ;
          state_nxt = S_EMIT;
        end else if (sts.action == ACT_NOP || !sts.started || sts.done) begin
          ev_nxt    = EV_IDLE;
          state_nxt = S_EMIT;
        end else begin
          cmd.op    = OP_RD_CUR;
          state_nxt = S_CUR_W;
        end
      end
      S_START_W: begin
        cmd.op    = OP_WR_VIS_ORIGIN;
        ev_nxt    = EV_IDLE;
        state_nxt = S_EMIT;
      end
      S_CUR_W: begin
        cmd.op    = OP_LATCH_CUR;
        state_nxt = S_ATT;
      end
      S_ATT: begin
        if (sts.att_end) begin
          if (!sts.stack_empty) begin
            cmd.op    = OP_RD_STACK;
            state_nxt = S_POP_W;
          end else if (sts.strip_over) begin
            cmd.op    = OP_FINISH;
            ev_nxt    = EV_FINISHED;
            state_nxt = S_EMIT;
          end else begin
            cmd.op    = OP_RD_STRIP;
            state_nxt = S_STRIP_W;
          end
        end else if (sts.nb_ok) begin
          cmd.op    = OP_RD_NB;
          state_nxt = S_NB_W;
        end else begin
          cmd.op = OP_NEXT_ATT;
        end
      end
      S_NB_W: begin
        if (sts.nb_visited) begin
          cmd.op    = OP_NEXT_ATT;
          state_nxt = S_ATT;
        end else begin
          cmd.op    = OP_WR_CUR;
          state_nxt = S_CARVE;
        end
      end
      S_CARVE: begin
        cmd.op    = OP_WR_NB;
        ev_nxt    = EV_CARVED;
        state_nxt = S_EMIT;
      end
      S_STRIP_W: begin
        cmd.op    = OP_WR_VIS_STRIP;
        ev_nxt    = EV_STRIP;
        state_nxt = S_EMIT;
      end
      S_POP_W: begin
        cmd.pop_load = 1'b1;
        ev_nxt       = EV_BACK;
        state_nxt    = S_EMIT;
      end
      S_EMIT: begin
        if (slot_free) begin
          cmd.result = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // output beat valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.result) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      ev_r        <= EV_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ev_r        <= ev_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ===== src/maze_backtracker_step.sv =====
// ----------------------------------------------------------------------------
// maze_backtracker_step
// Randomised depth-first maze growth over a grid, one action per input beat.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one action per beat: start,
//   step, read one cell or no operation, with the random picks and the read
//   coordinates. Every accepted beat gives exactly one result beat on the
//   output channel (out_valid/out_ready).
//   Configuration channel (cfg_valid/cfg_ready) writes the first row limit
//   (index 0) and the strip step (index 1); it is always ready.
//   Sequence for a taken beat: read, no-op and idle steps go from dispatch
//   to the result, a read fetching its cell; start reads the origin, then
//   marks it visited; a step reads and latches the current cell, then per
//   try reads and checks a neighbour, and then carves, backtracks through a
//   stack read, opens a strip or finishes. The next beat is taken after the
//   result is loaded. The single read port of the cell memory serialises
//   these reads. One item is in work at a time; a new beat is accepted while
//   the previous result still waits in the output register.
//   Reset: a clearing pass writes all COLUMNS*ROWS cells (4096 by default)
//   to all walls, unvisited, with in_ready low.
//   A stalled receiver holds the result; the next result waits until taken.
// ----------------------------------------------------------------------------
module maze_backtracker_step import mbs_pkg::*; #(
  parameter int COLUMNS = 16,
  parameter int ROWS    = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_action,
  input  logic [1:0]           in_pick_first,
  input  logic [1:0]           in_pick_second,
  input  logic                 in_pick_third,
  input  logic [X_FLD_W-1:0]   in_read_x,
  input  logic [Y_FLD_W-1:0]   in_read_y,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [2:0]           out_event_res,
  output logic [X_FLD_W-1:0]   out_pos_x,
  output logic [Y_FLD_W-1:0]   out_pos_y,
  output logic [1:0]           out_direction,
  output logic [3:0]           out_wall_bits,
  output logic                 out_cell_visited,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  cmd_t cmd;
  sts_t sts;

  // configuration writes are always taken
  assign cfg_ready = 1'b1;

  mbs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  mbs_dp #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_action        (in_action),
    .in_pick_first    (in_pick_first),
    .in_pick_second   (in_pick_second),
    .in_pick_third    (in_pick_third),
    .in_read_x        (in_read_x),
    .in_read_y        (in_read_y),
    .cfg_valid        (cfg_valid),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_event_res    (out_event_res),
    .out_pos_x        (out_pos_x),
    .out_pos_y        (out_pos_y),
    .out_direction    (out_direction),
    .out_wall_bits    (out_wall_bits),
    .out_cell_visited (out_cell_visited)
  );

endmodule

// ===== src/mbs_checker.sv =====
// ----------------------------------------------------------------------------
// mbs_checker
// Port-level checks on the maze backtracker step block, bound to the top.
// ----------------------------------------------------------------------------
module mbs_checker import mbs_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [2:0]         out_event_res,
  input logic [X_FLD_W-1:0] out_pos_x,
  input logic [Y_FLD_W-1:0] out_pos_y,
  input logic [1:0]         out_direction,
  input logic [3:0]         out_wall_bits,
  input logic               out_cell_visited
);

  // a stalled result beat stays
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // reset empties the output and starts the clearing pass
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_ready)
    else $error("channel active after reset");

  // only a cell read carries wall and visited bits
  a_walls: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_res != EV_READ |-> out_wall_bits == 4'd0 && !out_cell_visited)
    else $error("cell bits on a non-read beat");

  // finishing parks the walk at the origin
  a_finish: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_res == EV_FINISHED |->
      out_pos_x == '0 && out_pos_y == '0 && out_direction == 2'd0)
    else $error("finished beat away from origin");

endmodule

bind maze_backtracker_step mbs_checker u_mbs_checker (.*);

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for maze_backtracker_step. A scoreboard class keeps its
// own copy of the cell grid, the walk stack, the current cell and the row
// limit, works out each beat's expected result, and matches results in order.
// ----------------------------------------------------------------------------
module tb;
  import mbs_pkg::*;

  localparam int NCOLS     = 16;
  localparam int NROWS     = 256;
  localparam int NCELLS    = NCOLS * NROWS;
  localparam int MAX_CYCLE = 3000000;

  typedef struct {
    ev_t        ev;
    logic [3:0] x;
    logic [7:0] y;
    logic [1:0] dir;
    logic [3:0] walls;
    logic       vis;
  } maze_beat_t;

  // ---------------------------------------------------------------------------
  // scoreboard with its own maze state
  // ---------------------------------------------------------------------------
  class maze_tracker;
    bit [4:0]    cells [NCELLS];
    bit [11:0]   walk [NCELLS];
    int unsigned depth, cur, row_lim;
    bit          done, started;
    int unsigned first_lim, lim_step;
    maze_beat_t  pending_q [$];
    int          errors, matched, accepted;
    int          ev_seen [8];

    function new();
      foreach (cells[i]) cells[i] = {1'b0, ALL_WALLS};
      depth = 0; cur = 0; done = 0; started = 0;
      first_lim = FIRST_LIMIT_RST; lim_step = LIMIT_STEP_RST;
      row_lim = FIRST_LIMIT_RST;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      if (idx == CFG_FIRST_LIMIT) first_lim = val;
      else if (idx == CFG_LIMIT_STEP) lim_step = val;
    endfunction

    function void push_cell(int unsigned c);
      if (depth < NCELLS) begin
        walk[depth] = 12'(c);
        depth++;
      end
    endfunction

    // work out the result of one accepted action
    function void note_action(logic [1:0] act, logic [1:0] pf, logic [1:0] ps,
                              logic pt, logic [3:0] rx, logic [7:0] ry);
      maze_beat_t  r;
      int unsigned avail [4];
      int unsigned picks [3];
      int unsigned n, idx, dir, nb, cx, cy, prev, nxt;
      bit          ok, moved;
      r = '{ev: EV_IDLE, x: 0, y: 0, dir: 0, walls: 0, vis: 0};
      accepted++;
      avail = '{0, 1, 2, 3};
      picks = '{pf, ps, pt};
      moved = 0;
      n = 4;
      cx = cur % NCOLS;
      cy = cur / NCOLS;
      case (act_t'(act))
        ACT_START: begin
          cur = 0;
          cells[0][VIS_BIT] = 1'b1;
          push_cell(0);
          done = 0;
          started = 1;
          row_lim = first_lim;
        end
        ACT_READ: begin
          r.ev = EV_READ;
          r.x = rx;
          r.y = ry;
          r.walls = cells[ry * NCOLS + rx][3:0];
          r.vis = cells[ry * NCOLS + rx][VIS_BIT];
        end
        default: begin
          r.x = 4'(cx);
          r.y = 8'(cy);
          if (act_t'(act) == ACT_STEP && started && !done) begin
            // try directions in pick order, carve into first unvisited
            for (int a = 0; a < 4 && !moved; a++) begin
              idx = (a < 3) ? picks[a] % n : 0;
              dir = avail[idx];
              ok = 0;
              nb = 0;
              if (dir == DIR_UP) begin
                if (cy > 0) begin nb = cur - NCOLS; ok = 1; end
              end else if (dir == DIR_RIGHT) begin
                if (cx + 1 < NCOLS) begin nb = cur + 1; ok = 1; end
              end else if (dir == DIR_DOWN) begin
                if (cy + 1 < NROWS && cy + 1 < row_lim) begin nb = cur + NCOLS; ok = 1; end
              end else begin
                if (cx > 0) begin nb = cur - 1; ok = 1; end
              end
              if (ok && !cells[nb][VIS_BIT]) begin
                cells[cur][dir] = 1'b0;
                cells[nb][(dir + 2) % 4] = 1'b0;
                cells[nb][VIS_BIT] = 1'b1;
                cur = nb;
                push_cell(nb);
                r = '{ev: EV_CARVED, x: 4'(nb % NCOLS), y: 8'(nb / NCOLS), dir: 2'(dir),
                      walls: 0, vis: 0};
                moved = 1;
              end else begin
                for (int k = idx; k + 1 < n; k++) avail[k] = avail[k + 1];
                n--;
              end
            end
            if (!moved) begin
              if (depth > 0) begin
                // dead end: pop the top cell of the walk stack and move to it
                depth--;
                cur = walk[depth];
                r = '{ev: EV_BACK, x: 4'(cur % NCOLS), y: 8'(cur / NCOLS), dir: 0,
                      walls: 0, vis: 0};
              end else begin
                // stack exhausted: open a new strip or finish
                prev = row_lim;
                nxt = prev + lim_step;
                row_lim = (nxt > LIMIT_MAX) ? LIMIT_MAX : nxt;
                if (prev + 1 >= NROWS) begin
                  done = 1;
                  cur = 0;
                  r = '{ev: EV_FINISHED, x: 0, y: 0, dir: 0, walls: 0, vis: 0};
                end else begin
                  cur = (prev + 1) * NCOLS;
                  cells[cur][VIS_BIT] = 1'b1;
                  push_cell(cur);
                  r = '{ev: EV_STRIP, x: 0, y: 8'(prev + 1), dir: 0, walls: 0, vis: 0};
                end
              end
            end
          end
        end
      endcase
      pending_q = {pending_q, r};
    endfunction

    function void cmp_field(string name, int unsigned exp_v, int unsigned act_v);
      if (exp_v != act_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      end
    endfunction

    // match one result beat against the oldest expectation
    function void check_beat(logic [2:0] ev, logic [3:0] x, logic [7:0] y,
                             logic [1:0] dir, logic [3:0] walls, logic vis);
      maze_beat_t e;
      if (pending_q.size() == 0) begin
        errors++;
        $display("%0t: result beat with nothing expected, event %0d", $time, ev);
        return;
      end
      e = pending_q.pop_front();
      matched++;
      ev_seen[e.ev]++;
      cmp_field("event_res", e.ev, ev);
      cmp_field("pos_x", e.x, x);
      cmp_field("pos_y", e.y, y);
      cmp_field("direction", e.dir, dir);
      cmp_field("wall_bits", e.walls, walls);
      cmp_field("cell_visited", e.vis, vis);
    endfunction
  endclass

  logic                 clk = 0;
  logic                 rst_n = 0;
  logic                 in_valid = 0;
  logic                 in_ready;
  logic [1:0]           in_action = 0;
  logic [1:0]           in_pick_first = 0;
  logic [1:0]           in_pick_second = 0;
  logic                 in_pick_third = 0;
  logic [X_FLD_W-1:0]   in_read_x = 0;
  logic [Y_FLD_W-1:0]   in_read_y = 0;
  logic                 out_valid;
  logic                 out_ready = 1;
  logic [2:0]           out_event_res;
  logic [X_FLD_W-1:0]   out_pos_x;
  logic [Y_FLD_W-1:0]   out_pos_y;
  logic [1:0]           out_direction;
  logic [3:0]           out_wall_bits;
  logic                 out_cell_visited;
  logic                 cfg_valid = 0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = 0;
  logic [CFG_W-1:0]     cfg_data = 0;

  maze_tracker sb = new();
  bit          idle_on = 1;
  bit          held_off = 0;
  int          cycles = 0;

  maze_backtracker_step #(.COLUMNS(NCOLS), .ROWS(NROWS)) dut (.*);

  always #5 clk = ~clk;

  // timeout guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLE) begin
      $display("status: fail");
      $finish;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_beat(out_event_res, out_pos_x, out_pos_y, out_direction,
                    out_wall_bits, out_cell_visited);
  end

  // receiver: random stalls plus one long hold-off to back the block up
  initial begin
    forever begin
      if (!held_off && sb.accepted >= 200) begin
        out_ready <= 0;
        repeat (400) @(posedge clk);
        held_off = 1;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_ready <= 0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else begin
        out_ready <= 1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  end

  // one action beat, with an optional gap before it
  task send_action(logic [1:0] act, logic [1:0] pf, logic [1:0] ps, logic pt,
                   logic [3:0] rx, logic [7:0] ry);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid <= 1;
    in_action <= act;
    in_pick_first <= pf;
    in_pick_second <= ps;
    in_pick_third <= pt;
    in_read_x <= rx;
    in_read_y <= ry;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_action(act, pf, ps, pt, rx, ry);
  endtask

  task send_step(logic [1:0] pf, logic [1:0] ps, logic pt);
    send_action(ACT_STEP, pf, ps, pt, 4'($urandom), 8'($urandom));
  endtask

  task send_random();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 3)
      send_action(ACT_START, 2'($urandom), 2'($urandom), 1'($urandom),
                  4'($urandom), 8'($urandom));
    else if (sel < 8)
      send_action(ACT_NOP, 2'($urandom), 2'($urandom), 1'($urandom),
                  4'($urandom), 8'($urandom));
    else if (sel < 20)
      send_action(ACT_READ, 2'($urandom), 2'($urandom), 1'($urandom),
                  4'($urandom), 8'($urandom));
    else
      send_step(2'($urandom), 2'($urandom), 1'($urandom));
  endtask

  // one register write; the caller drops cfg_valid after the last one
  task write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  task drain();
    in_valid <= 0;
    @(posedge clk);
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // one configured phase of random beats, opened by a start
  task run_phase(logic [CFG_W-1:0] first_v, logic [CFG_W-1:0] step_v, int count);
    drain();
    write_cfg(CFG_FIRST_LIMIT, first_v);
    write_cfg(CFG_LIMIT_STEP, step_v);
    cfg_valid <= 0;
    send_action(ACT_START, 0, 0, 0, 0, 0);
    repeat (count) send_random();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1;
    // clearing pass after reset
    @(posedge clk);
    while (!in_ready) @(posedge clk);

    // directed: before start, no-op, corner reads, then short walk
    send_step(2'd1, 2'd2, 1'b1);
    send_action(ACT_NOP, 2'd3, 2'd3, 1'b1, 4'd15, 8'd255);
    send_action(ACT_READ, 0, 0, 0, 4'd0, 8'd0);
    send_action(ACT_READ, 2'd3, 2'd3, 1'b1, 4'd15, 8'd255);
    send_action(ACT_START, 0, 0, 0, 0, 0);
    send_step(2'd0, 2'd0, 1'b0);
    send_step(2'd3, 2'd3, 1'b1);
    send_step(2'd1, 2'd2, 1'b0);
    send_step(2'd2, 2'd1, 1'b1);
    send_step(2'd3, 2'd0, 1'b0);
    send_step(2'd0, 2'd3, 1'b1);
    send_action(ACT_READ, 0, 0, 0, 4'd0, 8'd0);
    send_action(ACT_READ, 0, 0, 0, 4'd1, 8'd0);
    send_action(ACT_READ, 0, 0, 0, 4'd0, 8'd1);
    send_action(ACT_READ, 0, 0, 0, 4'd15, 8'd0);
    send_action(ACT_START, 0, 0, 0, 0, 0);
    send_action(ACT_NOP, 0, 0, 0, 0, 0);

    // random phases across the register range
    run_phase(13'd1, 13'd1, 400);
    run_phase(13'd3, 13'd2, 350);
    run_phase(13'd4096, 13'd4096, 400);
    run_phase(13'd40, 13'd60, 400);

    // last part: no idling
    idle_on = 0;
    run_phase(13'd200, 13'd4096, 180);
    send_action(ACT_READ, 0, 0, 0, 4'd15, 8'd255);
    send_action(ACT_START, 0, 0, 0, 0, 0);

    drain();
    $display("covered %0d beats: %0d carved, %0d backtracked, %0d strips, %0d finished",
             sb.matched, sb.ev_seen[EV_CARVED], sb.ev_seen[EV_BACK],
             sb.ev_seen[EV_STRIP], sb.ev_seen[EV_FINISHED]);
    $display("also %0d idle and %0d cell reads, %0d mismatches",
             sb.ev_seen[EV_IDLE], sb.ev_seen[EV_READ], sb.errors);
    if (sb.errors == 0 && sb.pending_q.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

// ===== maze_backtracker_step.f =====
src/mbs_pkg.sv
src/mbs_ram.sv
src/mbs_dp.sv
src/mbs_ctrl.sv
src/maze_backtracker_step.sv
src/mbs_checker.sv
test/tb.sv
